[src/ctnp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the command-argument number scanner.
// No dependencies; used by every module under src.
package ctnp_pkg;

  // Character codes with a meaning of their own
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Digit value of a character that is no digit in any base
  localparam logic [5:0] DIGIT_NONE = 6'd63;

  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_MIN   = 6'd2;
  localparam logic [5:0] BASE_MAX   = 6'd36;

  // Upper bound on token slots per parse
  localparam int MAX_FIELDS = 5;

  localparam logic [31:0] VALUE_SAT = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [1:0] REG_NUMBER_BASE = 2'd0;
  localparam logic [1:0] REG_FIELD_COUNT = 2'd1;

  // One classified character, as queued between front and back
  typedef struct packed {
    logic       first;
    logic       is_nul;
    logic       is_space;
    logic       is_ws;
    logic       is_plus;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic [5:0] digit;
  } item_t;

  typedef struct packed {
    logic [5:0] number_base;
    logic [2:0] field_count;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  slot;
    logic [31:0] value;
    logic        present;
    logic [2:0]  fields_read;
    logic        last;
  } result_t;

endpackage

[src/ctnp_front.sv]
`timescale 1ns / 1ps
// Front end: classifies one incoming character into the flags the parser needs.
// Depends on ctnp_pkg.
module ctnp_front import ctnp_pkg::*; (
  input  logic [7:0] ch,
  input  logic       first,
  output item_t      item
);

  always_comb begin
    item          = '0;
    item.first    = first;
    item.is_nul   = (ch == CH_NUL);
    item.is_space = (ch == CH_SPACE);
    item.is_ws    = (ch inside {[8'd9:8'd13]});
    item.is_plus  = (ch == "+");
    item.is_minus = (ch == "-");
    item.is_zero  = (ch == "0");
    item.is_x     = (ch == "x") || (ch == "X");
    if (ch inside {["0":"9"]}) begin
      item.digit = 6'(ch - 8'h30);
    end else if (ch inside {["a":"z"]}) begin
      item.digit = 6'(ch - 8'h57);
    end else if (ch inside {["A":"Z"]}) begin
      item.digit = 6'(ch - 8'h37);
    end else begin
      item.digit = DIGIT_NONE;
    end
  end

endmodule

[src/ctnp_fifo.sv]
`timescale 1ns / 1ps
// Short queue of classified characters between front and back.
// Depends on ctnp_pkg for item_t.
module ctnp_fifo import ctnp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/ctnp_back.sv]
`timescale 1ns / 1ps
// Back end: tokenizer and strtoul conversion with the result output register, one
// character per cycle while that register is empty or taken. Depends on ctnp_pkg.
module ctnp_back import ctnp_pkg::*; #(
  parameter int MAX_TOKEN = 255
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int TL_W = $clog2(MAX_TOKEN + 1);

  typedef enum logic [2:0] {
    PH_WS, PH_PREFIX, PH_ZERO, PH_DIGITS, PH_STOP
  } conv_phase_t;

  // Parse state
  logic             parse_active;
  logic [2:0]       slot_index;
  logic [2:0]       token_count;
  logic [TL_W-1:0]  token_length;
  logic [31:0]      accumulator;
  logic             overflowed;
  logic             negative;
  conv_phase_t      conv_phase;
  logic [5:0]       eff_base;
  logic             swallow_next;

  logic             parse_active_next;
  logic [2:0]       slot_index_next;
  logic [2:0]       token_count_next;
  logic [TL_W-1:0]  token_length_next;
  logic [31:0]      accumulator_next;
  logic             overflowed_next;
  logic             negative_next;
  conv_phase_t      conv_phase_next;
  logic [5:0]       eff_base_next;
  logic             swallow_next_next;
  logic             emit;
  result_t          emit_res;

  logic             base_ok;
  logic [3:0]       slot_limit;
  logic [37:0]      mac;

  assign item_pop = item_valid && (!res_valid || res_ready);

  assign base_ok = (cfg.number_base == BASE_AUTO) ||
                   ((cfg.number_base >= BASE_MIN) && (cfg.number_base <= BASE_MAX));

  always_comb begin
    if (cfg.field_count == 3'd0) begin
      slot_limit = 4'd1;
    end else if ({1'b0, cfg.field_count} > 4'(MAX_FIELDS)) begin
      slot_limit = 4'(MAX_FIELDS);
    end else begin
      slot_limit = {1'b0, cfg.field_count};
    end
  end

  always_comb begin
    logic        done;
    logic        do_add;
    logic        end_slot;
    logic        end_nul;
    logic        present;
    logic [3:0]  slot_inc;
    logic [31:0] mag;

    parse_active_next = parse_active;
    slot_index_next   = slot_index;
    token_count_next  = token_count;
    token_length_next = token_length;
    accumulator_next  = accumulator;
    overflowed_next   = overflowed;
    negative_next     = negative;
    conv_phase_next   = conv_phase;
    eff_base_next     = eff_base;
    swallow_next_next = swallow_next;
    emit              = 1'b0;
    emit_res          = '0;
    done              = 1'b0;
    do_add            = 1'b0;
    end_slot          = 1'b0;
    end_nul           = 1'b0;
    mac               = '0;

    // A marked first character restarts the parse
    if (item.first) begin
      parse_active_next = 1'b1;
      slot_index_next   = '0;
      token_count_next  = '0;
      swallow_next_next = 1'b0;
      token_length_next = '0;
      accumulator_next  = '0;
      overflowed_next   = 1'b0;
      negative_next     = 1'b0;
      conv_phase_next   = PH_WS;
      eff_base_next     = '0;
    end

    if (!parse_active_next) begin
      // idle: character dropped
    end else if (swallow_next_next) begin
      swallow_next_next = 1'b0;
    end else if (item.is_nul) begin
      end_slot = 1'b1;
      end_nul  = 1'b1;
    end else if (item.is_space) begin
      end_slot = 1'b1;
    end else begin
      // strtoul front matter: whitespace, sign, radix prefix
      if (conv_phase_next == PH_WS) begin
        if (item.is_ws) begin
          done = 1'b1;
        end else if (item.is_plus || item.is_minus) begin
          negative_next   = item.is_minus;
          conv_phase_next = PH_PREFIX;
          done            = 1'b1;
        end else begin
          conv_phase_next = PH_PREFIX;
        end
      end
      if (!done && conv_phase_next == PH_PREFIX) begin
        done = 1'b1;
        if (item.is_zero &&
            (cfg.number_base == BASE_AUTO || cfg.number_base == BASE_HEX)) begin
          conv_phase_next = PH_ZERO;
        end else begin
          eff_base_next   = !base_ok ? 6'd0 :
                            (cfg.number_base == BASE_AUTO ? BASE_DEC : cfg.number_base);
          conv_phase_next = PH_DIGITS;
          do_add          = 1'b1;
        end
      end
      if (!done && conv_phase_next == PH_ZERO) begin
        done            = 1'b1;
        conv_phase_next = PH_DIGITS;
        if (item.is_x) begin
          eff_base_next = BASE_HEX;
        end else begin
          eff_base_next = !base_ok ? 6'd0 :
                          (cfg.number_base == BASE_AUTO ? BASE_OCT : cfg.number_base);
          do_add        = 1'b1;
        end
      end
      if (!done && conv_phase_next == PH_DIGITS) begin
        do_add = 1'b1;
      end

      // One multiply-accumulate step
      if (do_add) begin
        if (item.digit >= eff_base_next) begin
          conv_phase_next = PH_STOP;
        end else if (!overflowed_next) begin
          mac = (38'(accumulator_next) * 38'(eff_base_next)) + 38'(item.digit);
          if (mac[37:32] != '0) begin
            overflowed_next  = 1'b1;
            accumulator_next = '0;
          end else begin
            accumulator_next = mac[31:0];
          end
        end
      end

      token_length_next = token_length_next + 1'b1;
      if (token_length_next >= TL_W'(MAX_TOKEN)) begin
        swallow_next_next = 1'b1;
        end_slot          = 1'b1;
      end
    end

    present  = (token_length_next != '0);
    slot_inc = {1'b0, slot_index_next} + 4'd1;
    mag      = negative_next ? (32'd0 - accumulator_next) : accumulator_next;

    if (end_slot) begin
      if (present) begin
        token_count_next = token_count_next + 1'b1;
      end
      emit                 = 1'b1;
      emit_res.slot        = slot_index_next;
      emit_res.value       = !present ? 32'd0 : (overflowed_next ? VALUE_SAT : mag);
      emit_res.present     = present;
      emit_res.fields_read = token_count_next;
      emit_res.last        = end_nul || (slot_inc >= slot_limit);
      slot_index_next      = slot_inc[2:0];
      if (emit_res.last) begin
        parse_active_next = 1'b0;
      end
      token_length_next = '0;
      accumulator_next  = '0;
      overflowed_next   = 1'b0;
      negative_next     = 1'b0;
      conv_phase_next   = PH_WS;
      eff_base_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_active <= 1'b0;
      slot_index   <= '0;
      token_count  <= '0;
      token_length <= '0;
      accumulator  <= '0;
      overflowed   <= 1'b0;
      negative     <= 1'b0;
      conv_phase   <= PH_WS;
      eff_base     <= '0;
      swallow_next <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (item_pop) begin
        parse_active <= parse_active_next;
        slot_index   <= slot_index_next;
        token_count  <= token_count_next;
        token_length <= token_length_next;
        accumulator  <= accumulator_next;
        overflowed   <= overflowed_next;
        negative     <= negative_next;
        conv_phase   <= conv_phase_next;
        eff_base     <= eff_base_next;
        swallow_next <= swallow_next_next;
      end
      if (item_pop && emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && emit) begin
      res <= emit_res;
    end
  end

endmodule

[src/cli_token_number_parser_core.sv]
`timescale 1ns / 1ps
// Top level of the command-argument number scanner: config registers, front
// classifier, word queue and conversion back end. Depends on ctnp_pkg.
//
// Usage:
//   s_*: one character word per beat, s_tdata[7:0] the byte, s_tuser marks the
//   first character of an argument string and restarts the parse. NUL ends
//   the string, a space separates token slots.
//   m_*: one word per ended slot (slot, value, present, fields_read);
//   m_tlast marks the word that finishes the parse.
//   Config channel: cfg_index 0 = number_base, 1 = field_count; always ready.
//   Write it only while idle: all results taken and the queue drained.
// Timing:
//   One character per cycle sustained while m_tready keeps up (one 32x6
//   multiply-accumulate each). An accepted character goes into the queue;
//   its result word is loaded into the output register when the back end pops it.
// Stall:
//   m_tready low holds the output word and stops the back end; once the
//   FIFO_DEPTH-word queue is full, s_tready drops.
// Reset: rst empties queue and output, drops any parse, base 10, one slot.
module cli_token_number_parser_core import ctnp_pkg::*; #(
  parameter int MAX_TOKEN  = 255,
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Character stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] first
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] slot, [34:3] value, [35] present,
                                 // [38:36] fields_read, [39] zero
  output logic        m_tlast,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  cfg_t    cfg;
  item_t   front_item;
  item_t   queue_item;
  logic    queue_full;
  logic    queue_valid;
  logic    queue_pop;
  logic    s_fire;
  result_t res;

  assign cfg_ready = 1'b1;
  assign s_tready  = !queue_full;
  assign s_fire    = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.number_base <= BASE_DEC;
      cfg.field_count <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUMBER_BASE: cfg.number_base <= cfg_data;
        REG_FIELD_COUNT: cfg.field_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  ctnp_front u_front (
    .ch    (s_tdata),
    .first (s_tuser),
    .item  (front_item)
  );

  ctnp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s_fire),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_valid),
    .pop_item  (queue_item)
  );

  ctnp_back #(
    .MAX_TOKEN (MAX_TOKEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (queue_valid),
    .item       (queue_item),
    .item_pop   (queue_pop),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {1'b0, res.fields_read, res.present, res.value, res.slot};
  assign m_tlast = res.last;

endmodule
